@@ rtl/at_response_line_classifier_top_defines.svh @@
// Assertion macros for the AT reply line classifier.
// Included by the top level; needs the clock and reset ports in scope.
`ifndef AT_RESPONSE_LINE_CLASSIFIER_TOP_DEFINES_SVH
`define AT_RESPONSE_LINE_CLASSIFIER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define ARLC_ASSERT_NOW(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error(msg);
`define ARLC_ASSERT_NEXT(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error(msg);
`else
`define ARLC_ASSERT_NOW(label, lhs, rhs, msg)
`define ARLC_ASSERT_NEXT(label, lhs, rhs, msg)
`endif

`endif

@@ rtl/arlc_pkg.sv @@
// Types and constants of the AT reply line classifier.
// No dependencies; used by at_response_line_classifier_top.
`timescale 1ns / 1ps

package arlc_pkg;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_MODULE_ERR = 2'd1,
      ST_INVALID    = 2'd2,
      ST_TOO_LONG   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RK_NONE       = 2'd0,
      RK_PLAIN_OK   = 2'd1,
      RK_OK_VALUE   = 2'd2,
      RK_MODULE_ERR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_SPACE  = 2'd0,
      PH_SIGNED = 2'd1,
      PH_DIGITS = 2'd2,
      PH_BAD    = 2'd3
   } phase_type;

   localparam logic ACT_BYTE    = 1'b0;
   localparam logic ACT_DISCARD = 1'b1;

   // Bit positions in the prefix match flags.
   localparam int PF_OK   = 0;
   localparam int PF_OKEQ = 1;
   localparam int PF_ERR  = 2;

   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_0     = 8'h30;
   localparam logic [7:0] CHR_9     = 8'h39;
   localparam logic [7:0] CHR_EQ    = 8'h3D;
   localparam logic [7:0] CHR_E     = 8'h45;
   localparam logic [7:0] CHR_K     = 8'h4B;
   localparam logic [7:0] CHR_O     = 8'h4F;
   localparam logic [7:0] CHR_R     = 8'h52;

   localparam logic [35:0] POS_LIMIT = 36'h0_7FFF_FFFF;
   localparam logic [35:0] NEG_LIMIT = 36'h0_8000_0000;

endpackage

@@ rtl/at_response_line_classifier_top.sv @@
// AT reply line classifier: input register, per-byte classification logic and
// result register. Depends on arlc_pkg and at_response_line_classifier_top_defines.svh.
//
//   channel  direction  payload (lowest bits first)
//   req_     in         tuser: action; tdata: rx_byte
//   rsp_     out        tuser: status, reply_kind; tdata: module_error_code, line_length
//   csr_     in         wdata: line_capacity (write only)
//
// One byte is accepted per cycle unless a stalled result holds it back. The byte that
// ends the line passes the input register; its result is held in the result register.
// The rate is set by the line state update, which is done once per byte.
// A stalled result blocks only bytes that would give a further result; the input
// register then holds and req_tready drops. Reset is synchronous and clears all
// line state; the capacity register returns to 1024 (or MAX_CAPACITY if smaller).
`timescale 1ns / 1ps
`include "at_response_line_classifier_top_defines.svh"

module at_response_line_classifier_top #(
   parameter int MAX_CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] module_error_code, [41:32] line_length
   output logic [3:0]  rsp_tuser,   // [1:0] status, [3:2] reply_kind
   input  logic        csr_wen,
   input  logic [10:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_CAPACITY);
   localparam int RST_CAP = (MAX_CAPACITY < 1024) ? MAX_CAPACITY : 1024;
   localparam logic [CNT_W-1:0] RST_LINE_MAX = CNT_W'(RST_CAP - 1);

   // Configuration: stored as the highest byte count a line may hold.
   logic [CNT_W-1:0] line_max_ff, line_max_in;

   // Input register.
   logic       s1_valid_ff;
   logic       s1_action_ff;
   logic [7:0] s1_byte_ff;

   // Line state.
   logic [CNT_W-1:0]    byte_count_ff, byte_count_in;
   logic                last_was_cr_ff, last_was_cr_in;
   logic [2:0]          flags_ff, flags_in;
   arlc_pkg::phase_type phase_ff, phase_in;
   logic                neg_ff, neg_in;
   logic [31:0]         mag_ff, mag_in;
   logic                ovf_ff, ovf_in;

   // Result register.
   logic                 rsp_valid_ff;
   arlc_pkg::status_type rsp_status_ff, rsp_status_in;
   arlc_pkg::kind_type   rsp_kind_ff, rsp_kind_in;
   logic [31:0]          rsp_code_ff, rsp_code_in;
   logic [9:0]           rsp_len_ff, rsp_len_in;

   logic                full, lf_end, has_result, s1_go, out_free, new_line;
   logic                is_digit, is_space, is_sign, feed_cr, feed_b, add_digit;
   logic                ok_miss, okeq_miss, err_miss;
   logic [3:0]          dval;
   logic [35:0]         acc, limit;
   logic [CNT_W-1:0]    len;
   logic [31:0]         wr_cap;
   arlc_pkg::phase_type phase_cr;

   always_comb begin
      wr_cap = 32'(csr_wdata);
      if (wr_cap < 32'd2) begin
         line_max_in = CNT_W'(1);
      end else if (wr_cap > 32'(MAX_CAPACITY)) begin
         line_max_in = CNT_W'(MAX_CAPACITY - 1);
      end else begin
         line_max_in = CNT_W'(wr_cap - 32'd1);
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign full       = byte_count_ff >= line_max_ff;
   assign lf_end     = last_was_cr_ff && (s1_byte_ff == arlc_pkg::CHR_LF);
   assign has_result = s1_valid_ff && (s1_action_ff == arlc_pkg::ACT_BYTE) && (full || lf_end);
   assign s1_go      = s1_valid_ff && (!has_result || out_free);
   assign req_tready = !s1_valid_ff || s1_go;
   assign new_line   = (s1_action_ff == arlc_pkg::ACT_DISCARD) || has_result;

   // Prefix matching against "+OK", "+OK=" and "+ERR=".
   always_comb begin
      ok_miss = ((byte_count_ff == CNT_W'(0)) && (s1_byte_ff != arlc_pkg::CHR_PLUS)) ||
                ((byte_count_ff == CNT_W'(1)) && (s1_byte_ff != arlc_pkg::CHR_O)) ||
                ((byte_count_ff == CNT_W'(2)) && (s1_byte_ff != arlc_pkg::CHR_K));
      okeq_miss = (byte_count_ff == CNT_W'(3)) && (s1_byte_ff != arlc_pkg::CHR_EQ);
      err_miss = ((byte_count_ff == CNT_W'(0)) && (s1_byte_ff != arlc_pkg::CHR_PLUS)) ||
                 ((byte_count_ff == CNT_W'(1)) && (s1_byte_ff != arlc_pkg::CHR_E)) ||
                 ((byte_count_ff == CNT_W'(2)) && (s1_byte_ff != arlc_pkg::CHR_R)) ||
                 ((byte_count_ff == CNT_W'(3)) && (s1_byte_ff != arlc_pkg::CHR_R)) ||
                 ((byte_count_ff == CNT_W'(4)) && (s1_byte_ff != arlc_pkg::CHR_EQ));
      flags_in = flags_ff;
      if (ok_miss) begin
         flags_in[arlc_pkg::PF_OK]   = 1'b0;
         flags_in[arlc_pkg::PF_OKEQ] = 1'b0;
      end
      if (okeq_miss) begin
         flags_in[arlc_pkg::PF_OKEQ] = 1'b0;
      end
      if (err_miss) begin
         flags_in[arlc_pkg::PF_ERR] = 1'b0;
      end
   end

   // Number parser. A held CR that is not followed by LF is fed as whitespace
   // first; the current byte is fed afterwards unless it is itself a CR.
   always_comb begin
      is_digit = (s1_byte_ff >= arlc_pkg::CHR_0) && (s1_byte_ff <= arlc_pkg::CHR_9);
      is_space = (s1_byte_ff == arlc_pkg::CHR_SPACE) ||
                 ((s1_byte_ff >= arlc_pkg::CHR_TAB) && (s1_byte_ff <= arlc_pkg::CHR_CR));
      is_sign  = (s1_byte_ff == arlc_pkg::CHR_PLUS) || (s1_byte_ff == arlc_pkg::CHR_MINUS);
      dval     = 4'(s1_byte_ff - arlc_pkg::CHR_0);
      feed_cr  = last_was_cr_ff && (byte_count_ff >= CNT_W'(6));
      feed_b   = (s1_byte_ff != arlc_pkg::CHR_CR) && (byte_count_ff >= CNT_W'(5));
      phase_cr = (feed_cr && (phase_ff != arlc_pkg::PH_SPACE)) ? arlc_pkg::PH_BAD : phase_ff;
      acc      = 36'({mag_ff, 3'b000}) + 36'({mag_ff, 1'b0}) + 36'(dval);
      limit    = neg_ff ? arlc_pkg::NEG_LIMIT : arlc_pkg::POS_LIMIT;

      phase_in  = phase_cr;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      ovf_in    = ovf_ff;
      add_digit = 1'b0;
      if (feed_b) begin
         unique case (phase_cr)
            arlc_pkg::PH_SPACE: begin
               priority if (is_space) begin
                  phase_in = arlc_pkg::PH_SPACE;
               end else if (is_sign) begin
                  neg_in   = (s1_byte_ff == arlc_pkg::CHR_MINUS);
                  phase_in = arlc_pkg::PH_SIGNED;
               end else if (is_digit) begin
                  add_digit = 1'b1;
                  phase_in  = arlc_pkg::PH_DIGITS;
               end else begin
                  phase_in = arlc_pkg::PH_BAD;
               end
            end
            arlc_pkg::PH_SIGNED, arlc_pkg::PH_DIGITS: begin
               if (is_digit) begin
                  add_digit = 1'b1;
                  phase_in  = arlc_pkg::PH_DIGITS;
               end else begin
                  phase_in = arlc_pkg::PH_BAD;
               end
            end
            arlc_pkg::PH_BAD: begin
               phase_in = arlc_pkg::PH_BAD;
            end
         endcase
      end
      if (add_digit && !ovf_ff) begin
         if (acc > limit) begin
            ovf_in = 1'b1;
         end else begin
            mag_in = acc[31:0];
         end
      end
   end

   // Line bookkeeping and classification.
   always_comb begin
      len            = byte_count_ff + CNT_W'(1);
      byte_count_in  = new_line ? '0 : len;
      last_was_cr_in = !new_line && (s1_byte_ff == arlc_pkg::CHR_CR);

      rsp_status_in = arlc_pkg::ST_INVALID;
      rsp_kind_in   = arlc_pkg::RK_NONE;
      rsp_code_in   = '0;
      rsp_len_in    = 10'(len);
      priority if (full) begin
         rsp_status_in = arlc_pkg::ST_TOO_LONG;
         rsp_len_in    = 10'(byte_count_ff);
      end else if ((32'(len) == 32'd5) && flags_in[arlc_pkg::PF_OK]) begin
         rsp_status_in = arlc_pkg::ST_OK;
         rsp_kind_in   = arlc_pkg::RK_PLAIN_OK;
      end else if ((32'(len) > 32'd6) && flags_in[arlc_pkg::PF_OKEQ]) begin
         rsp_status_in = arlc_pkg::ST_OK;
         rsp_kind_in   = arlc_pkg::RK_OK_VALUE;
      end else if ((32'(len) > 32'd7) && flags_in[arlc_pkg::PF_ERR] &&
                   (phase_ff == arlc_pkg::PH_DIGITS) && !ovf_ff) begin
         rsp_status_in = arlc_pkg::ST_MODULE_ERR;
         rsp_kind_in   = arlc_pkg::RK_MODULE_ERR;
         rsp_code_in   = neg_ff ? (32'd0 - mag_ff) : mag_ff;
      end else begin
         rsp_status_in = arlc_pkg::ST_INVALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_max_ff <= RST_LINE_MAX;
      end else if (csr_wen) begin
         line_max_ff <= line_max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_action_ff <= req_tuser;
         s1_byte_ff   <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         last_was_cr_ff <= 1'b0;
         flags_ff       <= 3'b111;
         phase_ff       <= arlc_pkg::PH_SPACE;
         neg_ff         <= 1'b0;
         mag_ff         <= '0;
         ovf_ff         <= 1'b0;
      end else if (s1_go) begin
         byte_count_ff  <= byte_count_in;
         last_was_cr_ff <= last_was_cr_in;
         if (new_line) begin
            flags_ff <= 3'b111;
            phase_ff <= arlc_pkg::PH_SPACE;
            neg_ff   <= 1'b0;
            mag_ff   <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            flags_ff <= flags_in;
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            mag_ff   <= mag_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && has_result) begin
         rsp_status_ff <= rsp_status_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_code_ff   <= rsp_code_in;
         rsp_len_ff    <= rsp_len_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_len_ff, rsp_code_ff};
   assign rsp_tuser  = {rsp_kind_ff, rsp_status_ff};

   `ARLC_ASSERT_NOW(a_plain_ok_len, rsp_valid_ff && (rsp_kind_ff == arlc_pkg::RK_PLAIN_OK), (rsp_len_ff == 10'd5) && (rsp_status_ff == arlc_pkg::ST_OK), "plain OK result with wrong length or status")
   `ARLC_ASSERT_NOW(a_ok_has_kind, rsp_valid_ff && (rsp_status_ff == arlc_pkg::ST_OK), (rsp_kind_ff == arlc_pkg::RK_PLAIN_OK) || (rsp_kind_ff == arlc_pkg::RK_OK_VALUE), "ok status without an OK reply kind")
   `ARLC_ASSERT_NOW(a_code_only_err, rsp_valid_ff && (rsp_code_ff != 32'd0), rsp_kind_ff == arlc_pkg::RK_MODULE_ERR, "nonzero error code outside a module error result")
   `ARLC_ASSERT_NEXT(a_result_restarts, s1_go && has_result, (byte_count_ff == '0) && !last_was_cr_ff && (flags_ff == 3'b111), "line state not cleared after a result")

endmodule

@@ tb/tb_at_response_line_classifier_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for at_response_line_classifier_top, the AT reply line classifier.
// Depends on arlc_pkg and the RTL. It sends byte streams, predicts each classified line
// and checks every response transaction field by field.

module tb_at_response_line_classifier_top;

   localparam int MAX_CAPACITY = 1024;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_ITEMS  = 45;
   localparam int PHASE_COUNT  = 10;

   typedef struct packed {
      arlc_pkg::status_type status;
      arlc_pkg::kind_type   kind;
      logic signed [31:0]   code;
      logic [9:0]           length;
   } line_result_type;

   typedef logic [7:0] byte_q_type [$];

   typedef enum {DIR_TEXT, DIR_BYTE, DIR_DISCARD, DIR_CAPACITY} dir_op_type;

   typedef struct {
      dir_op_type      op;
      string           text;
      logic [10:0]     value;
      bit              typed;
      line_result_type want;
   } dir_row_type;

   localparam line_result_type NO_RESULT = '{status: arlc_pkg::ST_OK,
                                             kind: arlc_pkg::RK_NONE,
                                             code: 32'sd0, length: 10'd0};

   localparam logic [7:0] OK_TEXT [3]  = '{arlc_pkg::CHR_PLUS, arlc_pkg::CHR_O,
                                           arlc_pkg::CHR_K};
   localparam logic [7:0] ERR_TEXT [5] = '{arlc_pkg::CHR_PLUS, arlc_pkg::CHR_E,
                                           arlc_pkg::CHR_R, arlc_pkg::CHR_R,
                                           arlc_pkg::CHR_EQ};
   localparam logic [7:0] BLANKS [6]   = '{arlc_pkg::CHR_SPACE, arlc_pkg::CHR_TAB,
                                           arlc_pkg::CHR_LF, 8'h0B, 8'h0C,
                                           arlc_pkg::CHR_CR};
   localparam logic [7:0] NOISE_CHARS [8] = '{arlc_pkg::CHR_CR, arlc_pkg::CHR_LF,
                                              arlc_pkg::CHR_PLUS, arlc_pkg::CHR_O,
                                              arlc_pkg::CHR_K, arlc_pkg::CHR_EQ,
                                              arlc_pkg::CHR_E, arlc_pkg::CHR_R};
   localparam logic [10:0] PHASE_CAPS [PHASE_COUNT] = '{11'd1024, 11'd7, 11'd2047, 11'd0,
                                                        11'd1, 11'd2, 11'd3, 11'd64,
                                                        11'd1024, 11'd1024};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        req_tuser;   // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // [31:0] module_error_code, [41:32] line_length
   logic [3:0]  rsp_tuser;   // [1:0] status, [3:2] reply_kind
   logic        csr_wen;
   logic [10:0] csr_wdata;

   // Line state of the classifier as predicted here.
   logic [10:0]         capacity_setting;
   int                  held_count;
   bit                  cr_pending;
   logic [2:0]          prefix_flags;
   arlc_pkg::phase_type num_phase;
   bit                  num_negative;
   logic [31:0]         num_magnitude;
   bit                  num_overflow;

   line_result_type pending_lines [$];
   bit              traffic_gaps = 1'b1;
   int              cycle_count  = 0;
   int              items_sent   = 0;
   int              results_seen = 0;
   int              mismatches   = 0;
   int              settings_used = 0;
   int              by_status [4] = '{0, 0, 0, 0};

   dir_row_type directed_rows [11] = '{
      '{DIR_TEXT, "+OK\r\n", 11'd0, 1'b1,
        '{arlc_pkg::ST_OK, arlc_pkg::RK_PLAIN_OK, 32'sd0, 10'd5}},
      '{DIR_TEXT, "+OK=\377\r\n", 11'd0, 1'b1,
        '{arlc_pkg::ST_OK, arlc_pkg::RK_OK_VALUE, 32'sd0, 10'd7}},
      '{DIR_TEXT, "+ERR=-7\r\n", 11'd0, 1'b1,
        '{arlc_pkg::ST_MODULE_ERR, arlc_pkg::RK_MODULE_ERR, -32'sd7, 10'd9}},
      '{DIR_TEXT, "+", 11'd0, 1'b0, NO_RESULT},
      '{DIR_DISCARD, "", 11'h0AA, 1'b0, NO_RESULT},
      '{DIR_CAPACITY, "", 11'd0, 1'b0, NO_RESULT},
      '{DIR_BYTE, "", 11'h000, 1'b0, NO_RESULT},
      '{DIR_BYTE, "", 11'h080, 1'b1,
        '{arlc_pkg::ST_TOO_LONG, arlc_pkg::RK_NONE, 32'sd0, 10'd1}},
      '{DIR_BYTE, "", 11'h00A, 1'b0, NO_RESULT},
      '{DIR_CAPACITY, "", 11'd2047, 1'b0, NO_RESULT},
      '{DIR_TEXT, "\r\n", 11'd0, 1'b1,
        '{arlc_pkg::ST_INVALID, arlc_pkg::RK_NONE, 32'sd0, 10'd3}}
   };

   at_response_line_classifier_top #(
      .MAX_CAPACITY(MAX_CAPACITY)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic void start_line();
      held_count    = 0;
      cr_pending    = 1'b0;
      prefix_flags  = 3'b111;
      num_phase     = arlc_pkg::PH_SPACE;
      num_negative  = 1'b0;
      num_magnitude = '0;
      num_overflow  = 1'b0;
   endfunction

   function automatic void push_digit(logic [7:0] b);
      logic [31:0] digit;
      logic [31:0] limit;
      digit = 32'(b) - 32'(arlc_pkg::CHR_0);
      limit = num_negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (!num_overflow) begin
         if (num_magnitude > (limit - digit) / 32'd10) begin
            num_overflow = 1'b1;
         end else begin
            num_magnitude = num_magnitude * 32'd10 + digit;
         end
      end
   endfunction

   // Only bytes after the five-byte error prefix take part in the number.
   function automatic void feed_number(int pos, logic [7:0] b);
      bit digit;
      bit blank;
      digit = (b >= arlc_pkg::CHR_0) && (b <= arlc_pkg::CHR_9);
      blank = (b == arlc_pkg::CHR_SPACE) ||
              (b >= arlc_pkg::CHR_TAB && b <= arlc_pkg::CHR_CR);
      if (pos >= 5) begin
         case (num_phase)
            arlc_pkg::PH_SPACE: begin
               if (b == arlc_pkg::CHR_PLUS || b == arlc_pkg::CHR_MINUS) begin
                  num_negative = (b == arlc_pkg::CHR_MINUS);
                  num_phase    = arlc_pkg::PH_SIGNED;
               end else if (digit) begin
                  push_digit(b);
                  num_phase = arlc_pkg::PH_DIGITS;
               end else if (!blank) begin
                  num_phase = arlc_pkg::PH_BAD;
               end
            end
            arlc_pkg::PH_SIGNED, arlc_pkg::PH_DIGITS: begin
               if (digit) begin
                  push_digit(b);
                  num_phase = arlc_pkg::PH_DIGITS;
               end else begin
                  num_phase = arlc_pkg::PH_BAD;
               end
            end
            default: num_phase = arlc_pkg::PH_BAD;
         endcase
      end
   endfunction

   // Returns 1 when the transaction closes a line, with the classification in res.
   function automatic bit classify_byte(logic act, logic [7:0] b, output line_result_type res);
      int eff_cap;
      int len;
      res = NO_RESULT;
      if (act == arlc_pkg::ACT_DISCARD) begin
         start_line();
         return 1'b0;
      end
      eff_cap = int'(capacity_setting);
      if (eff_cap < 2) eff_cap = 2;
      if (eff_cap > MAX_CAPACITY) eff_cap = MAX_CAPACITY;
      if (held_count + 1 >= eff_cap) begin
         res.status = arlc_pkg::ST_TOO_LONG;
         res.length = 10'(held_count);
         start_line();
         return 1'b1;
      end
      if (held_count < 3 && b != OK_TEXT[held_count]) begin
         prefix_flags[arlc_pkg::PF_OK]   = 1'b0;
         prefix_flags[arlc_pkg::PF_OKEQ] = 1'b0;
      end
      if (held_count == 3 && b != arlc_pkg::CHR_EQ) prefix_flags[arlc_pkg::PF_OKEQ] = 1'b0;
      if (held_count < 5 && b != ERR_TEXT[held_count]) prefix_flags[arlc_pkg::PF_ERR] = 1'b0;
      if (!(cr_pending && b == arlc_pkg::CHR_LF)) begin
         // A CR that was not followed by LF becomes an ordinary line byte.
         if (cr_pending && held_count > 0) feed_number(held_count - 1, arlc_pkg::CHR_CR);
         if (b == arlc_pkg::CHR_CR) begin
            cr_pending = 1'b1;
         end else begin
            feed_number(held_count, b);
            cr_pending = 1'b0;
         end
         held_count++;
         return 1'b0;
      end
      len = held_count + 1;
      res.status = arlc_pkg::ST_INVALID;
      res.length = 10'(len);
      if (len == 5 && prefix_flags[arlc_pkg::PF_OK]) begin
         res.status = arlc_pkg::ST_OK;
         res.kind   = arlc_pkg::RK_PLAIN_OK;
      end else if (len > 6 && prefix_flags[arlc_pkg::PF_OKEQ]) begin
         res.status = arlc_pkg::ST_OK;
         res.kind   = arlc_pkg::RK_OK_VALUE;
      end else if (len > 7 && prefix_flags[arlc_pkg::PF_ERR] &&
                   num_phase == arlc_pkg::PH_DIGITS && !num_overflow) begin
         res.status = arlc_pkg::ST_MODULE_ERR;
         res.kind   = arlc_pkg::RK_MODULE_ERR;
         res.code   = num_negative ? (32'd0 - num_magnitude) : num_magnitude;
      end
      start_line();
      return 1'b1;
   endfunction

   function automatic void append_text(ref byte_q_type q, input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   task automatic send_item(input logic act, input logic [7:0] data, input bit typed,
                            input line_result_type want);
      line_result_type got;
      if (traffic_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (classify_byte(act, data, got)) pending_lines.push_back(typed ? want : got);
   endtask

   task automatic send_byte(input logic [7:0] data);
      send_item(arlc_pkg::ACT_BYTE, data, 1'b0, NO_RESULT);
   endtask

   // Lets every expected line come out and the input register empty before returning.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [10:0] value);
      wait_drained();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      capacity_setting = value;
      settings_used++;
   endtask

   task automatic send_random_line();
      byte_q_type      text;
      int              pick;
      int              n;
      longint unsigned mag;
      pick = $urandom_range(0, 15);
      case (pick)
         0, 1: append_text(text, "+OK\r\n");
         2, 3, 4: begin
            append_text(text, "+OK=");
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom));
            append_text(text, "\r\n");
         end
         5, 6, 7, 8, 9: begin
            append_text(text, "+ERR=");
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 3)) text.push_back(BLANKS[$urandom_range(0, 5)]);
            end
            n = $urandom_range(0, 3);
            if (n == 0) text.push_back(arlc_pkg::CHR_PLUS);
            else if (n == 1) text.push_back(arlc_pkg::CHR_MINUS);
            case ($urandom_range(0, 7))
               0: mag = 64'd2147483647;
               1: mag = 64'd2147483648;
               2: mag = 64'd2147483649;
               3: mag = 64'd99999999999;
               4: mag = 64'($urandom_range(0, 9));
               default: mag = 64'($urandom >> $urandom_range(0, 31));
            endcase
            if ($urandom_range(0, 7) == 0) append_text(text, "00");
            if ($urandom_range(0, 15) != 0) append_text(text, $sformatf("%0d", mag));
            if ($urandom_range(0, 15) == 0) text.push_back(arlc_pkg::CHR_SPACE);
            append_text(text, "\r\n");
         end
         10, 11: begin
            repeat ($urandom_range(1, 10)) begin
               if ($urandom_range(0, 3) == 0) text.push_back(NOISE_CHARS[$urandom_range(0, 7)]);
               else text.push_back(8'($urandom));
            end
            append_text(text, "\r\n");
         end
         12: begin
            // A lone CR inside the line must not end it.
            if ($urandom_range(0, 1) == 1) append_text(text, "+OK\r");
            else append_text(text, "+ERR=1\r");
            text.push_back(8'($urandom));
            append_text(text, "\r\n");
         end
         default: begin
            append_text(text, $sformatf("+ERR=%0d\r\n", $urandom));
            n = $urandom_range(0, text.size() - 1);
            while (text.size() > n) void'(text.pop_back());
         end
      endcase
      if (pick < 10 && $urandom_range(0, 7) == 0) begin
         text[$urandom_range(0, text.size() - 1)] = 8'($urandom);
      end
      foreach (text[i]) send_byte(text[i]);
      if (pick > 12) send_item(arlc_pkg::ACT_DISCARD, 8'($urandom), 1'b0, NO_RESULT);
   endtask

   always @(posedge clock) begin : check_lines
      line_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_lines.size() == 0) begin
            $error("unexpected result transaction: tuser %h tdata %h", rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_lines.pop_front();
            by_status[want.status]++;
            if (rsp_tuser[1:0] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser[1:0]);
               mismatches++;
            end
            if (rsp_tuser[3:2] !== want.kind) begin
               $error("reply_kind: expected %0d, actual %0d", want.kind, rsp_tuser[3:2]);
               mismatches++;
            end
            if (rsp_tdata[31:0] !== want.code) begin
               $error("module_error_code: expected %0d, actual %0d", want.code,
                      $signed(rsp_tdata[31:0]));
               mismatches++;
            end
            if (rsp_tdata[41:32] !== want.length) begin
               $error("line_length: expected %0d, actual %0d", want.length, rsp_tdata[41:32]);
               mismatches++;
            end
         end
      end
   end

   initial begin : drain_results
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (traffic_gaps && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[at_response_line_classifier_top] ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [10:0] cap;
      int          phase_start;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= arlc_pkg::ACT_BYTE;
      req_tdata  <= 8'h00;
      csr_wen    <= 1'b0;
      csr_wdata  <= 11'd0;
      capacity_setting = 11'd1024;
      start_line();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         case (directed_rows[r].op)
            DIR_CAPACITY: write_capacity(directed_rows[r].value);
            DIR_DISCARD: begin
               send_item(arlc_pkg::ACT_DISCARD, directed_rows[r].value[7:0], 1'b0,
                         NO_RESULT);
            end
            DIR_BYTE: begin
               send_item(arlc_pkg::ACT_BYTE, directed_rows[r].value[7:0],
                         directed_rows[r].typed, directed_rows[r].want);
            end
            default: begin
               for (int i = 0; i < directed_rows[r].text.len(); i++) begin
                  send_item(arlc_pkg::ACT_BYTE, directed_rows[r].text[i],
                            directed_rows[r].typed && i == directed_rows[r].text.len() - 1,
                            directed_rows[r].want);
               end
            end
         endcase
      end

      // Each phase runs under one capacity; the last one runs without any idling.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         cap = (p == PHASE_COUNT - 2) ? 11'($urandom_range(0, 2047)) : PHASE_CAPS[p];
         write_capacity(cap);
         traffic_gaps = (p < PHASE_COUNT - 1);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) send_random_line();
      end
      wait_drained();

      $display("Sent %0d transactions under %0d capacity settings; %0d lines came back.",
               items_sent, settings_used, results_seen);
      $display("By status: %0d ok, %0d module error, %0d invalid, %0d too long.",
               by_status[arlc_pkg::ST_OK], by_status[arlc_pkg::ST_MODULE_ERR],
               by_status[arlc_pkg::ST_INVALID], by_status[arlc_pkg::ST_TOO_LONG]);
      if (mismatches == 0 && pending_lines.size() == 0) begin
         $display("[at_response_line_classifier_top] OK");
      end else begin
         $display("[at_response_line_classifier_top] ERROR");
      end
      $finish;
   end

endmodule
